// ===== rtl/bcm_pkg.sv =====
package bcm_pkg;

    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = 4;
    localparam int REG_IDX_W    = 2;
    localparam int OP_MODE_W    = 1;
    localparam int PASS_COUNT_W = 4;
    localparam int ROW_WIDTH_W  = 7;

    localparam logic [REG_IDX_W-1:0] REG_OP_MODE    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PASS_COUNT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW_WIDTH  = 2'd2;

    localparam logic [OP_MODE_W-1:0]    OP_MODE_RESET    = 1'b0;
    localparam logic [PASS_COUNT_W-1:0] PASS_COUNT_RESET = 4'd1;
    localparam logic [ROW_WIDTH_W-1:0]  ROW_WIDTH_RESET  = 7'd64;

    typedef struct packed {
        logic erode;
        logic enable;
        logic clear;
    } bcm_stage_ctrl_t;

endpackage

// ===== rtl/bcm_lane.sv =====
module bcm_lane (
    input  logic in_image,
    input  logic erode,
    input  logic above,
    input  logic left,
    input  logic center,
    input  logic right,
    input  logic below,
    output logic pixel
);

    logic any_set;
    logic all_set;

    assign any_set = above | left | center | right | below;
    assign all_set = above & left & center & right & below;
    assign pixel   = in_image & (erode ? all_set : any_set);

endmodule

// ===== rtl/bcm_pass_core.sv =====
module bcm_pass_core #(
    parameter int ROW_WIDTH = 64
) (
    input  logic                 erode,
    input  logic [ROW_WIDTH-1:0] width_mask,
    input  logic [ROW_WIDTH-1:0] above_row,
    input  logic [ROW_WIDTH-1:0] cur_row,
    input  logic [ROW_WIDTH-1:0] below_row,
    output logic [ROW_WIDTH-1:0] result_row
);

    logic [ROW_WIDTH-1:0] above_m;
    logic [ROW_WIDTH-1:0] cur_m;
    logic [ROW_WIDTH-1:0] below_m;
    logic [ROW_WIDTH-1:0] lane_px;

    assign above_m = above_row & width_mask;
    assign cur_m   = cur_row & width_mask;
    assign below_m = below_row & width_mask;

    for (genvar j = 0; j < ROW_WIDTH; j++) begin : g_lane
        logic left_px;
        logic right_px;

        if (j == 0) begin : g_left_edge
            assign left_px = 1'b0;
        end else begin : g_left_in
            assign left_px = cur_m[j-1];
        end

        if (j == ROW_WIDTH - 1) begin : g_right_edge
            assign right_px = 1'b0;
        end else begin : g_right_in
            assign right_px = cur_m[j+1];
        end

        bcm_lane u_lane (
            .in_image (width_mask[j]),
            .erode    (erode),
            .above    (above_m[j]),
            .left     (left_px),
            .center   (cur_m[j]),
            .right    (right_px),
            .below    (below_m[j]),
            .pixel    (lane_px[j])
        );
    end

    assign result_row = lane_px & width_mask;

endmodule

// ===== rtl/bcm_stage.sv =====
module bcm_stage #(
    parameter int ROW_WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  bcm_pkg::bcm_stage_ctrl_t ctrl,
    input  logic [ROW_WIDTH-1:0]     width_mask,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ROW_WIDTH-1:0]     in_row,
    input  logic                     in_last,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [ROW_WIDTH-1:0]     out_row,
    output logic                     out_last
);

    import bcm_pkg::*;

    typedef enum logic [1:0] {
        FILL_EMPTY,
        FILL_TOP,
        FILL_FULL
    } fill_t;

    fill_t                fill_reg, fill_next;
    logic                 flush_reg, flush_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ROW_WIDTH-1:0] out_row_reg, out_row_next;
    logic                 out_last_reg, out_last_next;
    logic [ROW_WIDTH-1:0] above_reg, above_next;
    logic [ROW_WIDTH-1:0] cur_reg, cur_next;

    logic                 slot_free;
    logic [ROW_WIDTH-1:0] core_above;
    logic [ROW_WIDTH-1:0] core_cur;
    logic [ROW_WIDTH-1:0] core_below;
    logic [ROW_WIDTH-1:0] core_row;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = slot_free && !flush_reg;

    always_comb begin
        core_above = (fill_reg == FILL_FULL) ? above_reg : '0;
        core_cur   = cur_reg;
        core_below = in_row;
        if (flush_reg) begin
            core_below = '0;
        end else if (fill_reg == FILL_EMPTY) begin
            core_cur   = in_row;
            core_below = '0;
        end
    end

    bcm_pass_core #(
        .ROW_WIDTH (ROW_WIDTH)
    ) u_core (
        .erode      (ctrl.erode),
        .width_mask (width_mask),
        .above_row  (core_above),
        .cur_row    (core_cur),
        .below_row  (core_below),
        .result_row (core_row)
    );

    always_comb begin
        fill_next      = fill_reg;
        flush_next     = flush_reg;
        out_valid_next = out_valid_reg;
        out_row_next   = out_row_reg;
        out_last_next  = out_last_reg;
        above_next     = above_reg;
        cur_next       = cur_reg;

        if (slot_free) begin
            out_valid_next = 1'b0;
        end

        if (ctrl.clear) begin
            fill_next      = FILL_EMPTY;
            flush_next     = 1'b0;
            out_valid_next = 1'b0;
        end else if (flush_reg) begin
            if (slot_free) begin
                out_valid_next = 1'b1;
                out_row_next   = core_row;
                out_last_next  = 1'b1;
                fill_next      = FILL_EMPTY;
                flush_next     = 1'b0;
            end
        end else if (in_valid && in_ready) begin
            if (!ctrl.enable) begin
                out_valid_next = 1'b1;
                out_row_next   = in_row;
                out_last_next  = in_last;
            end else if (fill_reg == FILL_EMPTY) begin
                cur_next = in_row;
                if (in_last) begin
                    out_valid_next = 1'b1;
                    out_row_next   = core_row;
                    out_last_next  = 1'b1;
                end else begin
                    fill_next = FILL_TOP;
                end
            end else begin
                out_valid_next = 1'b1;
                out_row_next   = core_row;
                out_last_next  = 1'b0;
                above_next     = cur_reg;
                cur_next       = in_row;
                fill_next      = FILL_FULL;
                flush_next     = in_last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_row_reg  <= out_row_next;
        out_last_reg <= out_last_next;
        above_reg    <= above_next;
        cur_reg      <= cur_next;
        if (!aresetn) begin
            fill_reg      <= FILL_EMPTY;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/binary_cross_morphology.sv =====
// Every result leaves through the output register of each of the MAX_PASSES pass stages,
// disabled ones included. The chain takes one row per cycle while no stage stalls; each
// active pass stage holds off new rows while it emits its flush row after the bottom row.
// Throughput is set by the row registers in each pass stage, one result slot per stage.
// Reset clears the stage fill levels and all handshake valids, and loads op_mode 0,
// pass_count 1, row_width 64; the stored rows of each stage are not cleared.
module binary_cross_morphology #(
    parameter int ROW_WIDTH  = 64,
    parameter int MAX_PASSES = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bcm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bcm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bcm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ROW_WIDTH-1:0]           s_row_bits,
    input  logic                           s_last_row,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ROW_WIDTH-1:0]           m_result_bits,
    output logic                           m_frame_end
);

    import bcm_pkg::*;

    localparam logic [ROW_WIDTH_W-1:0] WIDTH_MAX = ROW_WIDTH_W'(ROW_WIDTH);
    localparam logic [4:0]             PASS_MAX  = 5'(MAX_PASSES);

    logic [OP_MODE_W-1:0]    op_mode_reg;
    logic [PASS_COUNT_W-1:0] pass_count_reg;
    logic [ROW_WIDTH_W-1:0]  row_width_reg;

    logic                    cfg_write;
    logic [REG_IDX_W-1:0]    reg_idx;
    logic                    pass_clear;
    logic [ROW_WIDTH_W-1:0]  eff_width;
    logic [4:0]              eff_passes;
    logic [ROW_WIDTH-1:0]    width_mask;

    logic                    chain_valid [MAX_PASSES+1];
    logic                    chain_ready [MAX_PASSES+1];
    logic [ROW_WIDTH-1:0]    chain_row   [MAX_PASSES+1];
    logic                    chain_last  [MAX_PASSES+1];

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign reg_idx    = paddr[CFG_ADDR_W-1:2];
    assign pass_clear = cfg_write && (reg_idx == REG_PASS_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg    <= OP_MODE_RESET;
            pass_count_reg <= PASS_COUNT_RESET;
            row_width_reg  <= ROW_WIDTH_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_OP_MODE:    op_mode_reg    <= pwdata[OP_MODE_W-1:0];
                REG_PASS_COUNT: pass_count_reg <= pwdata[PASS_COUNT_W-1:0];
                REG_ROW_WIDTH:  row_width_reg  <= pwdata[ROW_WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_OP_MODE:    prdata = CFG_DATA_W'(op_mode_reg);
            REG_PASS_COUNT: prdata = CFG_DATA_W'(pass_count_reg);
            REG_ROW_WIDTH:  prdata = CFG_DATA_W'(row_width_reg);
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        eff_width = row_width_reg;
        if (row_width_reg == '0) begin
            eff_width = ROW_WIDTH_W'(1);
        end else if (row_width_reg > WIDTH_MAX) begin
            eff_width = WIDTH_MAX;
        end
        eff_passes = {1'b0, pass_count_reg};
        if (eff_passes > PASS_MAX) begin
            eff_passes = PASS_MAX;
        end
    end

    for (genvar j = 0; j < ROW_WIDTH; j++) begin : g_mask
        assign width_mask[j] = ROW_WIDTH_W'(j) < eff_width;
    end

    assign chain_valid[0] = s_valid;
    assign s_ready        = chain_ready[0];
    assign chain_row[0]   = s_row_bits & width_mask;
    assign chain_last[0]  = s_last_row;

    for (genvar k = 0; k < MAX_PASSES; k++) begin : g_pass
        bcm_stage_ctrl_t stage_ctrl;

        assign stage_ctrl.erode  = op_mode_reg[0];
        assign stage_ctrl.enable = 5'(k) < eff_passes;
        assign stage_ctrl.clear  = pass_clear;

        bcm_stage #(
            .ROW_WIDTH (ROW_WIDTH)
        ) u_stage (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (stage_ctrl),
            .width_mask (width_mask),
            .in_valid   (chain_valid[k]),
            .in_ready   (chain_ready[k]),
            .in_row     (chain_row[k]),
            .in_last    (chain_last[k]),
            .out_valid  (chain_valid[k+1]),
            .out_ready  (chain_ready[k+1]),
            .out_row    (chain_row[k+1]),
            .out_last   (chain_last[k+1])
        );
    end

    assign chain_ready[MAX_PASSES] = m_ready;
    assign m_valid                 = chain_valid[MAX_PASSES];
    assign m_result_bits           = chain_row[MAX_PASSES] & width_mask;
    assign m_frame_end             = chain_last[MAX_PASSES];

endmodule
